/* hdl/rad_pkg.sv */
// ----------------------------------------------------------------------------
// rad_pkg: shared definitions for the averaged diversity selector
// Widths, register codes, reset values and the status bundle passed from
// the path selector to the top level.
// ----------------------------------------------------------------------------
package rad_pkg;

	// boxcar depth, must be a power of two
	localparam int AVG_LOG2  = 4;
	localparam int AVG_DEPTH = 1 << AVG_LOG2;

	// converter reading width and the ten-bit reduced value
	localparam int ADC_BITS  = 12;
	localparam int MEAN_W    = 10;
	localparam int ADC_SHIFT = ADC_BITS - MEAN_W;
	localparam int SUM_W     = MEAN_W + AVG_LOG2;

	localparam int TIME_W    = 32;
	localparam int HYST_W    = 10;
	localparam int DWELL_W   = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 2;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W  = 56;
	localparam int OUT_DATA_W = 24;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_HYST  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_DWELL = 2'd1;

	localparam logic [HYST_W-1:0]  HYST_RESET  = 10'd5;
	localparam logic [DWELL_W-1:0] DWELL_RESET = 24'd100000;

	// selector outcome for the current beat
	typedef struct packed {
		logic active;
		logic switched;
	} sel_t;

endpackage

/* hdl/rad_boxcar.sv */
// ----------------------------------------------------------------------------
// rad_boxcar: running boxcar average for one receiver
// Holds the sample ring and its running sum; gives the mean that includes
// the sample now presented and commits it when upd is high.
// ----------------------------------------------------------------------------
module rad_boxcar (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic [rad_pkg::AVG_LOG2-1:0]  pos,
	input  logic [rad_pkg::ADC_BITS-1:0]  sample,
	output logic [rad_pkg::MEAN_W-1:0]    mean
);

	logic [rad_pkg::MEAN_W-1:0] ring_q [rad_pkg::AVG_DEPTH];
	logic [rad_pkg::SUM_W-1:0]  sum_q;
	logic [rad_pkg::MEAN_W-1:0] val;
	logic [rad_pkg::SUM_W-1:0]  sum_nx;

	// drop the low converter bits
	assign val = sample[rad_pkg::ADC_BITS-1 -: rad_pkg::MEAN_W];

	// swap the oldest entry for the new one; the sum never underflows
	assign sum_nx = sum_q
		- {{(rad_pkg::SUM_W - rad_pkg::MEAN_W){1'b0}}, ring_q[pos]}
		+ {{(rad_pkg::SUM_W - rad_pkg::MEAN_W){1'b0}}, val};

	// divide by the depth
	assign mean = sum_nx[rad_pkg::SUM_W-1 -: rad_pkg::MEAN_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			for (int i = 0; i < rad_pkg::AVG_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
		end else if (upd) begin
			sum_q       <= sum_nx;
			ring_q[pos] <= val;
		end
	end

endmodule

/* hdl/rad_select.sv */
// ----------------------------------------------------------------------------
// rad_select: path decision with hysteresis and dwell deadline
// Compares the two means, tracks the target path and its deadline, and
// switches the active path once the deadline has been reached.
// ----------------------------------------------------------------------------
module rad_select (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          upd,
	input  logic [rad_pkg::MEAN_W-1:0]    mean_a,
	input  logic [rad_pkg::MEAN_W-1:0]    mean_b,
	input  logic [rad_pkg::TIME_W-1:0]    now_us,
	input  logic [rad_pkg::HYST_W-1:0]    hysteresis,
	input  logic [rad_pkg::DWELL_W-1:0]   dwell_us,
	output rad_pkg::sel_t                 sel
);

	logic                        current_q;
	logic                        target_q;
	logic [rad_pkg::TIME_W-1:0]  deadline_q;

	logic                        a_gt;
	logic                        a_lt;
	logic                        best;
	logic [rad_pkg::MEAN_W-1:0]  absdiff;
	logic                        meets;
	logic [rad_pkg::TIME_W-1:0]  elapsed;
	logic                        reached;
	logic [rad_pkg::TIME_W-1:0]  rearm;

	logic                        current_nx;
	logic                        target_nx;
	logic [rad_pkg::TIME_W-1:0]  deadline_nx;
	logic                        switched_nx;

	// compare the means; a tie keeps the current path
	assign a_gt    = mean_a > mean_b;
	assign a_lt    = mean_a < mean_b;
	assign best    = a_gt ? 1'b0 : (a_lt ? 1'b1 : current_q);
	assign absdiff = a_gt ? (mean_a - mean_b) : (mean_b - mean_a);
	assign meets   = absdiff >= hysteresis;

	// wrap-safe deadline check and a fresh deadline from now
	assign elapsed = now_us - deadline_q;
	assign reached = ~elapsed[rad_pkg::TIME_W-1];
	assign rearm   = now_us + {{(rad_pkg::TIME_W - rad_pkg::DWELL_W){1'b0}}, dwell_us};

	// next decision state
	always_comb begin
		current_nx  = current_q;
		target_nx   = target_q;
		deadline_nx = deadline_q;
		switched_nx = 1'b0;
		if (meets) begin
			if (best == target_q) begin
				if (reached && (current_q != target_q)) begin
					current_nx  = target_q;
					switched_nx = 1'b1;
				end
			end else begin
				target_nx   = best;
				deadline_nx = rearm;
			end
		end else begin
			deadline_nx = rearm;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			current_q  <= 1'b0;
			target_q   <= 1'b0;
			deadline_q <= '0;
		end else if (upd) begin
			current_q  <= current_nx;
			target_q   <= target_nx;
			deadline_q <= deadline_nx;
		end
	end

	assign sel.active   = current_nx;
	assign sel.switched = switched_nx;

endmodule

/* hdl/rssi_average_diversity_select.sv */
// ----------------------------------------------------------------------------
// rssi_average_diversity_select: two-path receive diversity selector
// Averages the signal strength of two receivers over a boxcar window and
// picks the stronger path with hysteresis and a dwell time.
// ----------------------------------------------------------------------------
// Pipeline: an accepted input beat passes the input register, then the
// output register, where output back-pressure can hold it.
// Throughput: one beat per cycle while the output is not stalled; the ring,
// sum and dwell check are updated in a single pass between the two registers.
// Reset: asynchronous, clears rings, sums, paths and deadline at once and
// loads the register defaults; no clearing pass.
module rssi_average_diversity_select (
	input  logic                              clk,
	input  logic                              arst_n,
	// slave side
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sample_a [11:0], sample_b [23:12], now_us [55:24]
	input  logic [rad_pkg::IN_DATA_W-1:0]     s_tdata,
	// master side
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// active_path [0], mean_a [10:1], mean_b [20:11], switched [21]
	output logic [rad_pkg::OUT_DATA_W-1:0]    m_tdata,
	// configuration
	input  logic                              cfg_we,
	input  logic [rad_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rad_pkg::CFG_W-1:0]         cfg_data
);

	logic [rad_pkg::HYST_W-1:0]   hyst_q;
	logic [rad_pkg::DWELL_W-1:0]  dwell_q;

	logic                         vld_s1;
	logic [rad_pkg::ADC_BITS-1:0] a_s1;
	logic [rad_pkg::ADC_BITS-1:0] b_s1;
	logic [rad_pkg::TIME_W-1:0]   now_s1;

	logic                         vld_s2;
	logic [rad_pkg::OUT_DATA_W-1:0] tdata_s2;

	logic [rad_pkg::AVG_LOG2-1:0] pos_q;
	logic                         adv;
	logic [rad_pkg::MEAN_W-1:0]   mean_a;
	logic [rad_pkg::MEAN_W-1:0]   mean_b;
	rad_pkg::sel_t                sel;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hyst_q  <= rad_pkg::HYST_RESET;
			dwell_q <= rad_pkg::DWELL_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				rad_pkg::REG_HYST:  hyst_q  <= cfg_data[rad_pkg::HYST_W-1:0];
				rad_pkg::REG_DWELL: dwell_q <= cfg_data[rad_pkg::DWELL_W-1:0];
				default: ;
			endcase
		end
	end

	// stage 1 moves on when the output register is free or being emptied
	assign adv      = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready = !vld_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			a_s1   <= s_tdata[11:0];
			b_s1   <= s_tdata[23:12];
			now_s1 <= s_tdata[55:24];
		end
	end

	// shared ring write position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (adv) begin
			pos_q <= pos_q + 1'b1;
		end
	end

	rad_boxcar u_box_a (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.pos    (pos_q),
		.sample (a_s1),
		.mean   (mean_a)
	);

	rad_boxcar u_box_b (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (adv),
		.pos    (pos_q),
		.sample (b_s1),
		.mean   (mean_b)
	);

	rad_select u_sel (
		.clk        (clk),
		.arst_n     (arst_n),
		.upd        (adv),
		.mean_a     (mean_a),
		.mean_b     (mean_b),
		.now_us     (now_s1),
		.hysteresis (hyst_q),
		.dwell_us   (dwell_q),
		.sel        (sel)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2 <= 1'b1;
		end else if (m_tready) begin
			vld_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tdata_s2 <= {2'b00, sel.switched, mean_b, mean_a, sel.active};
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = tdata_s2;

	// an empty output register never holds back the input
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!vld_s2 |-> s_tready)
		else $error("input stalled with empty output register");

	// ring position steps once per processed beat
	a_pos_step: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> pos_q == $past(pos_q) + 1'b1)
		else $error("ring position did not advance");

	// the selector outcome, switch flag and active path, lands in the output beat
	a_switch_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> (m_tdata[21] == $past(sel.switched)) && (m_tdata[0] == $past(sel.active)))
		else $error("output beat does not match selector outcome");

endmodule

/* dv/tb_rssi_average_diversity_select.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rssi_average_diversity_select: self-checking bench for the selector
// Streams sample pairs with a running microsecond time into the block and
// predicts every result beat: boxcar means, target tracking, dwell deadline
// and path switches. Random gaps on the input side and random back-pressure
// on the output side; the registers are reprogrammed between phases.
// ----------------------------------------------------------------------------

import rad_pkg::*;

// path codes
localparam logic PATH_A = 1'b0;
localparam logic PATH_B = 1'b1;

// register indexes beyond the register list, writes there must be ignored
localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

typedef struct {
	logic              active;
	logic [MEAN_W-1:0] mean_a;
	logic [MEAN_W-1:0] mean_b;
	logic              switched;
} selection_t;

// predicts the selector outcome per input beat and checks result beats
class selection_board;
	logic [MEAN_W-1:0]   ring_a [AVG_DEPTH];
	logic [MEAN_W-1:0]   ring_b [AVG_DEPTH];
	logic [SUM_W-1:0]    sum_a;
	logic [SUM_W-1:0]    sum_b;
	logic [AVG_LOG2-1:0] pos;
	logic                current;
	logic                target;
	logic [TIME_W-1:0]   deadline;
	logic [HYST_W-1:0]   hyst;
	logic [TIME_W-1:0]   dwell;
	selection_t          pending_selections [$];
	int unsigned         results_seen;
	int unsigned         mismatches;

	function new();
		foreach (ring_a[i]) begin
			ring_a[i] = '0;
			ring_b[i] = '0;
		end
		sum_a        = '0;
		sum_b        = '0;
		pos          = '0;
		current      = PATH_A;
		target       = PATH_A;
		deadline     = '0;
		hyst         = HYST_RESET;
		dwell        = TIME_W'(DWELL_RESET);
		results_seen = 0;
		mismatches   = 0;
	endfunction

	function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		case (idx)
			REG_HYST:  hyst = data[HYST_W-1:0];
			REG_DWELL: dwell = TIME_W'(data[DWELL_W-1:0]);
			default: ;
		endcase
	endfunction

	// one accepted input beat: update the averages and the path tracker
	function void take_samples(logic [IN_DATA_W-1:0] beat);
		logic [ADC_BITS-1:0] raw_a;
		logic [ADC_BITS-1:0] raw_b;
		logic [TIME_W-1:0]   now;
		logic [TIME_W-1:0]   lag;
		logic [MEAN_W-1:0]   va;
		logic [MEAN_W-1:0]   vb;
		logic [MEAN_W-1:0]   ma;
		logic [MEAN_W-1:0]   mb;
		logic [MEAN_W-1:0]   spread;
		logic                best;
		selection_t          sel;

		raw_a = beat[ADC_BITS-1:0];
		raw_b = beat[2*ADC_BITS-1:ADC_BITS];
		now   = beat[2*ADC_BITS +: TIME_W];
		va    = MEAN_W'(raw_a >> ADC_SHIFT);
		vb    = MEAN_W'(raw_b >> ADC_SHIFT);

		// boxcar update, both rings share the write position
		sum_a       = sum_a - SUM_W'(ring_a[pos]) + SUM_W'(va);
		sum_b       = sum_b - SUM_W'(ring_b[pos]) + SUM_W'(vb);
		ring_a[pos] = va;
		ring_b[pos] = vb;
		pos         = pos + 1'b1;
		ma          = sum_a[SUM_W-1:AVG_LOG2];
		mb          = sum_b[SUM_W-1:AVG_LOG2];

		// equal means keep the current path as best
		if (ma > mb) begin
			best   = PATH_A;
			spread = ma - mb;
		end else if (ma < mb) begin
			best   = PATH_B;
			spread = mb - ma;
		end else begin
			best   = current;
			spread = '0;
		end

		sel.switched = 1'b0;
		if (spread >= hyst) begin
			if (best == target) begin
				// wrap-safe deadline check: signed (now - deadline) >= 0
				lag = now - deadline;
				if (!lag[TIME_W-1] && current != target) begin
					current      = target;
					sel.switched = 1'b1;
				end
			end else begin
				target   = best;
				deadline = now + dwell;
			end
		end else begin
			deadline = now + dwell;
		end

		sel.active = current;
		sel.mean_a = ma;
		sel.mean_b = mb;
		pending_selections.push_back(sel);
	endfunction

	task report(string what);
		mismatches++;
		if (mismatches <= 30)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// one accepted result beat against the oldest prediction
	task check_selection(logic [OUT_DATA_W-1:0] beat);
		selection_t want;
		selection_t got;
		logic [OUT_DATA_W-2*MEAN_W-3:0] pad;

		results_seen++;
		if (pending_selections.size() == 0) begin
			report($sformatf("result %0d with nothing pending, tdata %h", results_seen, beat));
			return;
		end
		want         = pending_selections.pop_front();
		got.active   = beat[0];
		got.mean_a   = beat[MEAN_W:1];
		got.mean_b   = beat[2*MEAN_W:MEAN_W+1];
		got.switched = beat[2*MEAN_W+1];
		pad          = beat[OUT_DATA_W-1:2*MEAN_W+2];

		if (got.active !== want.active)
			report($sformatf("result %0d active_path %b, predicted %b",
				results_seen, got.active, want.active));
		if (got.mean_a !== want.mean_a)
			report($sformatf("result %0d mean_a %0d, predicted %0d",
				results_seen, got.mean_a, want.mean_a));
		if (got.mean_b !== want.mean_b)
			report($sformatf("result %0d mean_b %0d, predicted %0d",
				results_seen, got.mean_b, want.mean_b));
		if (got.switched !== want.switched)
			report($sformatf("result %0d switched %b, predicted %b",
				results_seen, got.switched, want.switched));
		if (pad !== '0)
			report($sformatf("result %0d padding bits %b not zero", results_seen, pad));
	endtask
endclass

module tb_rssi_average_diversity_select;

	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam int unsigned RANDOM_ITEMS = 850;
	localparam int          PHASES       = 6;

	logic                  clk;
	logic                  arst_n    = 1'b0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata   = '0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_W-1:0]      cfg_data  = '0;

	selection_board board = new();
	bit             quiet_in;

	rssi_average_diversity_select dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// mostly short gaps, a few long ones, none at all in quiet stretches
	function automatic int pick_idle(bit quiet);
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// level plus uniform noise, clamped to the converter range
	function automatic logic [ADC_BITS-1:0] jitter(int level, int noise);
		int v;
		v = level - noise + int'($urandom_range(0, 2 * noise));
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return v[ADC_BITS-1:0];
	endfunction

	task write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		board.write_reg(idx, data);
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	// one input beat, after an optional gap; returns once it is accepted
	task send_samples(logic [ADC_BITS-1:0] a, logic [ADC_BITS-1:0] b,
			logic [TIME_W-1:0] now);
		int idle;
		idle = pick_idle(quiet_in);
		if (idle > 0) begin
			s_tvalid <= 1'b0;
			repeat (idle) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {now, b, a};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	// wait until every predicted result has arrived
	task drain();
		while (board.pending_selections.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// output back-pressure
	initial begin
		int  run;
		int  stall;
		bit  quiet_out;
		@(posedge clk);
		forever begin
			quiet_out = ($urandom_range(0, 9) == 0);
			run       = quiet_out ? $urandom_range(30, 100) : $urandom_range(1, 8);
			m_tready <= 1'b1;
			repeat (run) @(posedge clk);
			stall = pick_idle(quiet_out);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
		end
	end

	// beat monitors
	always @(posedge clk) begin
		if (arst_n && s_tvalid && s_tready)
			board.take_samples(s_tdata);
		if (arst_n && m_tvalid && m_tready)
			board.check_selection(m_tdata);
	end

	// watchdog
	initial begin
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

	// stimulus
	initial begin
		logic [CFG_W-1:0]    phase_hyst [PHASES];
		logic [CFG_W-1:0]    phase_dwell [PHASES];
		logic [TIME_W-1:0]   now;
		logic [TIME_W-1:0]   step_max;
		logic [DWELL_W-1:0]  dwell_now;
		logic [ADC_BITS-1:0] a;
		logic [ADC_BITS-1:0] b;
		int unsigned         sent;
		int unsigned         quota;
		int                  kind;
		int                  len;
		int                  hi;
		int                  lo;
		int                  noise;
		bit                  lead_b;

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: zero hysteresis and no dwell, time running across the wrap
		write_reg(REG_HYST, '0);
		write_reg(REG_DWELL, '0);
		quiet_in = 1'b0;
		now = 32'hFFFF_FFEA;
		// equal means with zero hysteresis, target already active
		send_samples('0, '0, now);
		now++;
		// first receiver strong: best is the active path, no switch
		for (int i = 0; i < 12; i++) begin
			send_samples(12'hFFF, '0, now);
			now++;
		end
		// second receiver takes over: equal means, new target, then switch
		for (int i = 0; i < 10; i++) begin
			send_samples('0, 12'hFFF, now);
			now++;
		end
		s_tvalid <= 1'b0;
		drain();

		// register settings per random phase, upper bits set where ignored
		phase_hyst[0]  = 24'hFFFFFF;
		phase_dwell[0] = 24'hFFFFFF;
		phase_hyst[1]  = 24'hABC005;
		phase_dwell[1] = 24'd100000;
		phase_hyst[2]  = '0;
		phase_dwell[2] = '0;
		phase_hyst[3]  = CFG_W'($urandom_range(1, 40));
		phase_dwell[3] = CFG_W'($urandom_range(1, 5000));
		phase_hyst[4]  = 24'h5A5401;
		phase_dwell[4] = 24'h800000;
		phase_hyst[5]  = CFG_W'($urandom);
		phase_dwell[5] = CFG_W'($urandom);

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_HYST, phase_hyst[p]);
			write_reg(REG_DWELL, phase_dwell[p]);
			write_reg((p % 2 == 0) ? REG_SPARE_LO : REG_SPARE_HI, CFG_W'($urandom));
			dwell_now = phase_dwell[p][DWELL_W-1:0];
			now   = (p == 4) ? 32'hFFF0_0000 : $urandom;
			sent  = 0;
			quota = RANDOM_ITEMS / PHASES;

			while (sent < quota) begin
				kind     = $urandom_range(0, 99);
				len      = $urandom_range(8, 40);
				quiet_in = ($urandom_range(0, 4) == 0);
				lead_b   = 1'($urandom_range(0, 1));
				hi       = $urandom_range(2048, 4095);
				lo       = $urandom_range(0, 2047);
				noise    = $urandom_range(0, 300);
				// full-scale contrast, long enough to fill the window
				if (kind < 15) begin
					hi    = 4095;
					lo    = 0;
					noise = 0;
					len   = $urandom_range(18, 40);
				end
				// mostly steps scaled to the dwell, now and then a huge jump
				if ($urandom_range(0, 9) == 0)
					step_max = 32'hFFFF_FFFF;
				else
					step_max = TIME_W'(dwell_now / 4) + 32'd8;

				for (int i = 0; i < len && sent < quota; i++) begin
					if (kind < 70) begin
						a   = jitter(lead_b ? lo : hi, noise);
						b   = jitter(lead_b ? hi : lo, noise);
						now = now + $urandom_range(0, step_max);
					end else if (kind < 85) begin
						// near-equal strengths around the hysteresis
						a   = jitter(hi, 3);
						b   = jitter(hi, 3);
						now = now + $urandom_range(0, step_max);
					end else begin
						a   = ADC_BITS'($urandom);
						b   = ADC_BITS'($urandom);
						now = $urandom;
					end
					send_samples(a, b, now);
					sent++;
				end
			end
			s_tvalid <= 1'b0;
			drain();
		end

		repeat (8) @(posedge clk);
		if (board.mismatches == 0 && board.pending_selections.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
